// ----- design/assert_macros.svh -----
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, also checked during reset
`define ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/ltem_pkg.sv -----
`default_nettype none

package ltem_pkg;

    // field widths
    localparam int CW     = 24;          // input coordinate / coefficient
    localparam int EW     = CW + 1;      // edge difference
    localparam int PW     = 2 * EW;      // edge product
    localparam int SW     = PW + 1;      // sum of products, determinant
    localparam int LOW_W  = 26;          // low slice of a split multiply
    localparam int HIGH_W = SW - LOW_W;  // high slice
    localparam int NW     = CW + SW;     // full coefficient product
    localparam int FRAC   = 16;          // input fraction bits
    localparam int DW     = NW + FRAC;   // dividend
    localparam int VW     = SW + 1;      // divisor
    localparam int QW     = 64;          // quotient / result
    localparam int HW     = DW - QW;     // dividend bits above the quotient

    localparam int NSTIFF    = 6;
    localparam int NLANE     = 8;
    localparam int LANE_DIAG = 6;
    localparam int LANE_OFF  = 7;

    // coefficient products: one per stiffness entry plus the shared mass one
    localparam int NPROD     = NSTIFF + 1;
    localparam int LANE_MASS = NSTIFF;

    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;
    localparam int INFW   = 2;

    // divider depth: input stage plus one stage per quotient bit
    localparam int DIV_LAT = QW + 1;

    // mass diagonal: sig*|D| / (12 * 2^16) = (sig*|D| >> 18) / 3
    localparam int MASS_SHIFT = FRAC + 2;
    // divide by 3 one 16-bit digit per stage, by reciprocal multiply
    localparam int D3W        = 16;
    localparam int D3_STEPS   = QW / D3W;
    localparam int D3PW       = 2 * (D3W + 2);
    localparam int DIV3_MUL   = 174763;   // ceil(2^19 / 3)
    localparam int DIV3_SHIFT = 19;

    // upper-triangle pair order of the stiffness entries
    localparam int PAIR_I [NSTIFF] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_J [NSTIFF] = '{0, 1, 2, 1, 2, 2};

    localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] NEG_MAG = {1'b1, {(QW-1){1'b0}}};

    // classified element handed from front to back
    typedef struct packed {
        logic                        degenerate;
        logic [NSTIFF-1:0]           neg;
        logic [NSTIFF-1:0][SW-1:0]   mag;
        logic [SW-1:0]               absd;
        logic [CW-1:0]               lam;
        logic [CW-1:0]               sig;
    } entry_t;

    // sideband travelling next to the divider lanes
    typedef struct packed {
        logic              degenerate;
        logic [NSTIFF-1:0] neg;
    } tag_t;

endpackage

`default_nettype wire

// ----- design/ltem_front.sv -----
`default_nettype none

module ltem_front
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              take,
    input  wire logic signed [ltem_pkg::CW-1:0]    x_first,
    input  wire logic signed [ltem_pkg::CW-1:0]    y_first,
    input  wire logic signed [ltem_pkg::CW-1:0]    x_second,
    input  wire logic signed [ltem_pkg::CW-1:0]    y_second,
    input  wire logic signed [ltem_pkg::CW-1:0]    x_third,
    input  wire logic signed [ltem_pkg::CW-1:0]    y_third,
    input  wire logic        [ltem_pkg::CW-1:0]    diffusion_coef,
    input  wire logic        [ltem_pkg::CW-1:0]    capacity_coef,
    output      logic                              push,
    output      ltem_pkg::entry_t                  entry,
    output      logic [ltem_pkg::INFW-1:0]         inflight
);

    logic v1_reg, v2_reg, v3_reg;

    logic signed [ltem_pkg::EW-1:0] a_reg [3];
    logic signed [ltem_pkg::EW-1:0] b_reg [3];
    logic signed [ltem_pkg::PW-1:0] pa_reg [ltem_pkg::NSTIFF];
    logic signed [ltem_pkg::PW-1:0] pb_reg [ltem_pkg::NSTIFF];
    logic signed [ltem_pkg::PW-1:0] pd1_reg, pd2_reg;
    logic signed [ltem_pkg::SW-1:0] s_reg [ltem_pkg::NSTIFF];
    logic signed [ltem_pkg::SW-1:0] det_reg;
    logic [ltem_pkg::CW-1:0] lam1_reg, lam2_reg, lam3_reg;
    logic [ltem_pkg::CW-1:0] sig1_reg, sig2_reg, sig3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // edge differences
    always_ff @(posedge clk)
    begin
        a_reg[0] <= ltem_pkg::EW'(y_second) - ltem_pkg::EW'(y_third);
        a_reg[1] <= ltem_pkg::EW'(y_third)  - ltem_pkg::EW'(y_first);
        a_reg[2] <= ltem_pkg::EW'(y_first)  - ltem_pkg::EW'(y_second);
        b_reg[0] <= ltem_pkg::EW'(x_third)  - ltem_pkg::EW'(x_second);
        b_reg[1] <= ltem_pkg::EW'(x_first)  - ltem_pkg::EW'(x_third);
        b_reg[2] <= ltem_pkg::EW'(x_second) - ltem_pkg::EW'(x_first);
        lam1_reg <= diffusion_coef;
        sig1_reg <= capacity_coef;
        lam2_reg <= lam1_reg;
        sig2_reg <= sig1_reg;
        lam3_reg <= lam2_reg;
        sig3_reg <= sig2_reg;
    end

    // products; det = b2*a1 - b1*a2
    for (genvar k = 0; k < ltem_pkg::NSTIFF; k++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            pa_reg[k] <= a_reg[ltem_pkg::PAIR_I[k]] * a_reg[ltem_pkg::PAIR_J[k]];
            pb_reg[k] <= b_reg[ltem_pkg::PAIR_I[k]] * b_reg[ltem_pkg::PAIR_J[k]];
            s_reg[k]  <= ltem_pkg::SW'(pa_reg[k]) + ltem_pkg::SW'(pb_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        pd1_reg <= b_reg[2] * a_reg[1];
        pd2_reg <= b_reg[1] * a_reg[2];
        det_reg <= ltem_pkg::SW'(pd1_reg) - ltem_pkg::SW'(pd2_reg);
    end

    // classify: degenerate flag, magnitudes and signs
    always_comb
    begin
        entry.degenerate = (det_reg == '0);
        entry.absd       = det_reg[ltem_pkg::SW-1] ? ltem_pkg::SW'(-det_reg)
                                                   : ltem_pkg::SW'(det_reg);
        entry.lam        = lam3_reg;
        entry.sig        = sig3_reg;
        for (int k = 0; k < ltem_pkg::NSTIFF; k++)
        begin
            entry.neg[k] = s_reg[k][ltem_pkg::SW-1];
            entry.mag[k] = s_reg[k][ltem_pkg::SW-1] ? ltem_pkg::SW'(-s_reg[k])
                                                    : ltem_pkg::SW'(s_reg[k]);
        end
    end

    assign push     = v3_reg;
    assign inflight = {1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, v3_reg};

endmodule

`default_nettype wire

// ----- design/ltem_fifo.sv -----
`default_nettype none

module ltem_fifo
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire ltem_pkg::entry_t            din,
    input  wire logic                        pop,
    output      ltem_pkg::entry_t            dout,
    output      logic                        empty,
    output      logic [ltem_pkg::QCW-1:0]    count
);

    ltem_pkg::entry_t              mem_reg [ltem_pkg::QDEPTH];
    logic [ltem_pkg::QPW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [ltem_pkg::QCW-1:0]      count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

`default_nettype wire

// ----- design/ltem_div_lane.sv -----
`default_nettype none

module ltem_div_lane
(
    input  wire logic                       clk,
    input  wire logic [ltem_pkg::DW-1:0]    dividend,
    input  wire logic [ltem_pkg::VW-1:0]    divisor,
    output      logic [ltem_pkg::QW-1:0]    quotient,
    output      logic                       ovf
);

    // restoring division, one quotient bit per stage; the word holds the
    // dividend bits still to come and the quotient bits already found
    logic [ltem_pkg::VW-1:0] rem_reg  [ltem_pkg::QW+1];
    logic [ltem_pkg::QW-1:0] word_reg [ltem_pkg::QW+1];
    logic [ltem_pkg::VW-1:0] dvs_reg  [ltem_pkg::QW+1];
    logic                    ovf_reg  [ltem_pkg::QW+1];
    logic [ltem_pkg::HW-1:0] top_bits;

    assign top_bits = dividend[ltem_pkg::DW-1:ltem_pkg::QW];

    // quotient needs more than QW bits when the top part reaches the divisor
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= ltem_pkg::VW'(top_bits);
        word_reg[0] <= dividend[ltem_pkg::QW-1:0];
        dvs_reg[0]  <= divisor;
        ovf_reg[0]  <= (ltem_pkg::VW'(top_bits) >= divisor);
    end

    for (genvar k = 0; k < ltem_pkg::QW; k++)
    begin : g_step
        logic [ltem_pkg::VW:0] trial;
        logic [ltem_pkg::VW:0] diff;
        logic                  ge;

        assign trial = {rem_reg[k], word_reg[k][ltem_pkg::QW-1]};
        assign diff  = trial - {1'b0, dvs_reg[k]};
        assign ge    = (trial >= {1'b0, dvs_reg[k]});

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= ge ? diff[ltem_pkg::VW-1:0] : trial[ltem_pkg::VW-1:0];
            word_reg[k+1] <= {word_reg[k][ltem_pkg::QW-2:0], ge};
            dvs_reg[k+1]  <= dvs_reg[k];
            ovf_reg[k+1]  <= ovf_reg[k];
        end
    end

    assign quotient = word_reg[ltem_pkg::QW];
    assign ovf      = ovf_reg[ltem_pkg::QW];

endmodule

`default_nettype wire

// ----- design/ltem_back.sv -----
`default_nettype none

module ltem_back
(
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          avail,
    input  wire ltem_pkg::entry_t                              entry,
    output      logic                                          pop,
    output      logic                                          done,
    output      logic [ltem_pkg::NLANE-1:0][ltem_pkg::QW-1:0]  result,
    output      logic                                          degenerate
);

    localparam int PLW = ltem_pkg::CW + ltem_pkg::LOW_W;
    localparam int PHW = ltem_pkg::CW + ltem_pkg::HIGH_W;

    logic                      v1_reg, v2_reg;
    logic                      dv_reg [ltem_pkg::DIV_LAT];
    ltem_pkg::tag_t            t1_reg, t2_reg;
    ltem_pkg::tag_t            dt_reg [ltem_pkg::DIV_LAT];
    logic [PLW-1:0]            pl_reg [ltem_pkg::NPROD];
    logic [PHW-1:0]            ph_reg [ltem_pkg::NPROD];
    logic [ltem_pkg::NW-1:0]   num_reg [ltem_pkg::NPROD];
    logic [ltem_pkg::SW-1:0]   absd1_reg, absd2_reg;
    logic [ltem_pkg::QW-1:0]   quo [ltem_pkg::NSTIFF];
    logic                      ovf [ltem_pkg::NSTIFF];
    logic [ltem_pkg::QW-1:0]   md_reg [ltem_pkg::DIV_LAT];
    logic [1:0]                mr_reg [ltem_pkg::D3_STEPS];
    logic [ltem_pkg::QW-1:0]   mass_q;
    logic [ltem_pkg::QW-1:0]   fin [ltem_pkg::NLANE];
    ltem_pkg::tag_t            tout;
    logic                      done_reg, deg_reg;
    logic [ltem_pkg::NLANE-1:0][ltem_pkg::QW-1:0] res_reg;

    // never stalls: take the queue head whenever there is one
    assign pop = avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < ltem_pkg::DIV_LAT; i++)
                dv_reg[i] <= 1'b0;
        end
        else
        begin
            v1_reg    <= avail;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int i = 1; i < ltem_pkg::DIV_LAT; i++)
                dv_reg[i] <= dv_reg[i-1];
            done_reg  <= dv_reg[ltem_pkg::DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg.degenerate <= entry.degenerate;
        t1_reg.neg        <= entry.neg;
        t2_reg            <= t1_reg;
        dt_reg[0]         <= t2_reg;
        for (int i = 1; i < ltem_pkg::DIV_LAT; i++)
            dt_reg[i] <= dt_reg[i-1];
        absd1_reg <= entry.absd;
        absd2_reg <= absd1_reg;
    end

    // split multiply: coefficient times low and high slice, then recombine
    for (genvar k = 0; k < ltem_pkg::NPROD; k++)
    begin : g_prod
        logic [ltem_pkg::CW-1:0] coef;
        logic [ltem_pkg::SW-1:0] opnd;

        if (k < ltem_pkg::NSTIFF)
        begin : g_stiff
            assign coef = entry.lam;
            assign opnd = entry.mag[k];
        end
        else
        begin : g_mass
            assign coef = entry.sig;
            assign opnd = entry.absd;
        end

        always_ff @(posedge clk)
        begin
            pl_reg[k]  <= PLW'(coef) * PLW'(opnd[ltem_pkg::LOW_W-1:0]);
            ph_reg[k]  <= PHW'(coef) * PHW'(opnd[ltem_pkg::SW-1:ltem_pkg::LOW_W]);
            num_reg[k] <= (ltem_pkg::NW'(ph_reg[k]) << ltem_pkg::LOW_W)
                          + ltem_pkg::NW'(pl_reg[k]);
        end
    end

    // stiffness lanes: pipelined division by 2|D|
    for (genvar k = 0; k < ltem_pkg::NSTIFF; k++)
    begin : g_lane
        logic [ltem_pkg::DW-1:0] dividend;
        logic [ltem_pkg::VW-1:0] divisor;
        logic                    over;
        logic [ltem_pkg::QW-1:0] mag_sat;

        assign dividend = {num_reg[k], {ltem_pkg::FRAC{1'b0}}};
        assign divisor  = {absd2_reg, 1'b0};

        ltem_div_lane u_div
        (
            .clk      (clk),
            .dividend (dividend),
            .divisor  (divisor),
            .quotient (quo[k]),
            .ovf      (ovf[k])
        );

        // saturate the magnitude, then apply the sign
        assign over    = ovf[k] || (tout.neg[k] ? (quo[k] > ltem_pkg::NEG_MAG)
                                                : quo[k][ltem_pkg::QW-1]);
        assign mag_sat = over ? (tout.neg[k] ? ltem_pkg::NEG_MAG : ltem_pkg::POS_MAX)
                              : quo[k];
        assign fin[k]  = tout.degenerate ? '0
                       : (tout.neg[k] ? (~mag_sat + 1'b1) : mag_sat);
    end

    // mass: scale sig*|D| down, divide by 3 a digit per stage, then ride
    // along with the divider lanes
    always_ff @(posedge clk)
    begin
        md_reg[0] <= ltem_pkg::QW'(num_reg[ltem_pkg::LANE_MASS] >> ltem_pkg::MASS_SHIFT);
        mr_reg[0] <= 2'b00;
    end

    for (genvar i = 1; i < ltem_pkg::DIV_LAT; i++)
    begin : g_mass_pipe
        if (i <= ltem_pkg::D3_STEPS)
        begin : g_div3
            logic [ltem_pkg::D3W+1:0]  x;
            logic [ltem_pkg::D3PW-1:0] prod;
            logic [ltem_pkg::D3W-1:0]  q;

            assign x    = {mr_reg[i-1], md_reg[i-1][ltem_pkg::QW-1 -: ltem_pkg::D3W]};
            assign prod = ltem_pkg::D3PW'(x) * ltem_pkg::D3PW'(ltem_pkg::DIV3_MUL);
            assign q    = prod[ltem_pkg::DIV3_SHIFT +: ltem_pkg::D3W];

            always_ff @(posedge clk)
            begin
                md_reg[i] <= {md_reg[i-1][ltem_pkg::QW-ltem_pkg::D3W-1:0], q};
            end

            if (i < ltem_pkg::D3_STEPS)
            begin : g_rem
                // remainder x - 3q is below 3, so two bits carry it exactly
                logic [1:0] r;
                assign r = x[1:0] - {q[0], 1'b0} - q[1:0];
                always_ff @(posedge clk)
                begin
                    mr_reg[i] <= r;
                end
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                md_reg[i] <= md_reg[i-1];
            end
        end
    end

    assign tout   = dt_reg[ltem_pkg::DIV_LAT-1];
    assign mass_q = md_reg[ltem_pkg::DIV_LAT-1];

    // off-diagonal is half the diagonal, rounded down
    assign fin[ltem_pkg::LANE_DIAG] = tout.degenerate ? '0 : mass_q;
    assign fin[ltem_pkg::LANE_OFF]  = tout.degenerate ? '0 : (mass_q >> 1);

    always_ff @(posedge clk)
    begin
        deg_reg <= tout.degenerate;
        for (int k = 0; k < ltem_pkg::NLANE; k++)
            res_reg[k] <= fin[k];
    end

    assign done       = done_reg;
    assign result     = res_reg;
    assign degenerate = deg_reg;

endmodule

`default_nettype wire

// ----- design/linear_triangle_element_matrices_top.sv -----
// P1 triangle element matrices. Each beat taken on start (with busy low)
// carries one triangle: three Q8.16 vertices, a diffusion coefficient and a
// capacity coefficient. For each taken triangle done pulses for one cycle
// with the six upper-triangle stiffness entries, the two mass matrix values
// (all Q31.32, saturated, truncated toward zero) and the degenerate flag;
// a zero-area triangle returns degenerate high and all entries zero. A new
// triangle can be taken every cycle; the latency is set by the six stiffness
// divider lanes, each pipelined one quotient bit per stage, while the mass
// values take a short divide-by-three pipeline and ride alongside. The result
// strobe cannot be held off: the receiver must take every beat the cycle it
// shows. busy rises only if the queue between the edge/determinant front end
// and the multiply/divide back end could fill, which a free-running back end
// never allows, so in practice busy stays low.
`default_nettype none

module linear_triangle_element_matrices_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic signed [ltem_pkg::CW-1:0]    x_first,
    input  wire logic signed [ltem_pkg::CW-1:0]    y_first,
    input  wire logic signed [ltem_pkg::CW-1:0]    x_second,
    input  wire logic signed [ltem_pkg::CW-1:0]    y_second,
    input  wire logic signed [ltem_pkg::CW-1:0]    x_third,
    input  wire logic signed [ltem_pkg::CW-1:0]    y_third,
    input  wire logic        [ltem_pkg::CW-1:0]    diffusion_coef,
    input  wire logic        [ltem_pkg::CW-1:0]    capacity_coef,
    output      logic                              done,
    output      logic signed [ltem_pkg::QW-1:0]    stiff_00,
    output      logic signed [ltem_pkg::QW-1:0]    stiff_01,
    output      logic signed [ltem_pkg::QW-1:0]    stiff_02,
    output      logic signed [ltem_pkg::QW-1:0]    stiff_11,
    output      logic signed [ltem_pkg::QW-1:0]    stiff_12,
    output      logic signed [ltem_pkg::QW-1:0]    stiff_22,
    output      logic signed [ltem_pkg::QW-1:0]    mass_diag,
    output      logic signed [ltem_pkg::QW-1:0]    mass_off,
    output      logic                              degenerate
);

    logic                                          take;
    logic                                          push;
    ltem_pkg::entry_t                              front_entry;
    ltem_pkg::entry_t                              head;
    logic [ltem_pkg::INFW-1:0]                     inflight;
    logic [ltem_pkg::QCW-1:0]                      q_count;
    logic                                          q_empty;
    logic                                          pop;
    logic [ltem_pkg::NLANE-1:0][ltem_pkg::QW-1:0]  result;

    // a beat is taken only when the queue, after this edge's pop, has room
    // for every triangle already in the front end plus this one
    assign busy = (q_count + ltem_pkg::QCW'(inflight) - ltem_pkg::QCW'(pop))
                  >= ltem_pkg::QCW'(ltem_pkg::QDEPTH);
    assign take = start && !busy;

    // front: edge terms, products, determinant, classification
    ltem_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .x_first        (x_first),
        .y_first        (y_first),
        .x_second       (x_second),
        .y_second       (y_second),
        .x_third        (x_third),
        .y_third        (y_third),
        .diffusion_coef (diffusion_coef),
        .capacity_coef  (capacity_coef),
        .push           (push),
        .entry          (front_entry),
        .inflight       (inflight)
    );

    // short queue decoupling the two halves
    ltem_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_entry),
        .pop   (pop),
        .dout  (head),
        .empty (q_empty),
        .count (q_count)
    );

    // back: coefficient multiply, pipelined division, saturation
    ltem_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .avail      (!q_empty),
        .entry      (head),
        .pop        (pop),
        .done       (done),
        .result     (result),
        .degenerate (degenerate)
    );

    assign stiff_00  = result[0];
    assign stiff_01  = result[1];
    assign stiff_02  = result[2];
    assign stiff_11  = result[3];
    assign stiff_12  = result[4];
    assign stiff_22  = result[5];
    assign mass_diag = result[ltem_pkg::LANE_DIAG];
    assign mass_off  = result[ltem_pkg::LANE_OFF];

endmodule

`default_nettype wire

// ----- design/ltem_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module ltem_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              done,
    input wire logic signed [ltem_pkg::QW-1:0]    stiff_00,
    input wire logic signed [ltem_pkg::QW-1:0]    stiff_01,
    input wire logic signed [ltem_pkg::QW-1:0]    stiff_02,
    input wire logic signed [ltem_pkg::QW-1:0]    stiff_11,
    input wire logic signed [ltem_pkg::QW-1:0]    stiff_12,
    input wire logic signed [ltem_pkg::QW-1:0]    stiff_22,
    input wire logic signed [ltem_pkg::QW-1:0]    mass_diag,
    input wire logic signed [ltem_pkg::QW-1:0]    mass_off,
    input wire logic                              degenerate
);

    logic entries_zero;
    logic mass_ok;
    logic diag_ok;

    assign entries_zero = (stiff_00 == '0) && (stiff_01 == '0) && (stiff_02 == '0)
                       && (stiff_11 == '0) && (stiff_12 == '0) && (stiff_22 == '0)
                       && (mass_diag == '0) && (mass_off == '0);
    assign mass_ok = !mass_diag[ltem_pkg::QW-1] && !mass_off[ltem_pkg::QW-1]
                  && (mass_diag >= mass_off);
    assign diag_ok = !stiff_00[ltem_pkg::QW-1] && !stiff_11[ltem_pkg::QW-1]
                  && !stiff_22[ltem_pkg::QW-1];

    // degenerate triangle gives all-zero entries
    `ASSERT_IMPLIES(a_degen_zero, clk, rst_n, done && degenerate, entries_zero)

    // mass values are nonnegative and the diagonal dominates
    `ASSERT_IMPLIES(a_mass_order, clk, rst_n, done, mass_ok)

    // stiffness diagonal is a sum of squares
    `ASSERT_IMPLIES(a_stiff_diag, clk, rst_n, done, diag_ok)

    // no beat appears straight out of reset
    `ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !done)

endmodule

bind linear_triangle_element_matrices_top ltem_checker u_ltem_checker (.*);

`default_nettype wire
